// ----- src/rbsi_pkg.sv -----
package rbsi_pkg;

	localparam int NUM_AXES  = 3;
	localparam int CFG_IDX_W = 3;
	localparam int MAT_W     = 8;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [MAT_W-1:0]     mat_t;
	typedef logic [1:0]           axis_t;

	localparam cfg_idx_t CFG_BOX_MIN_X = 3'd0;
	localparam cfg_idx_t CFG_BOX_MIN_Y = 3'd1;
	localparam cfg_idx_t CFG_BOX_MIN_Z = 3'd2;
	localparam cfg_idx_t CFG_BOX_MAX_X = 3'd3;
	localparam cfg_idx_t CFG_BOX_MAX_Y = 3'd4;
	localparam cfg_idx_t CFG_BOX_MAX_Z = 3'd5;
	localparam cfg_idx_t CFG_MATERIAL  = 3'd6;

	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

endpackage

// ----- src/rbsi_if.sv -----
interface rbsi_ray_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] origin_x;
	logic signed [W-1:0] origin_y;
	logic signed [W-1:0] origin_z;
	logic signed [W-1:0] dir_x;
	logic signed [W-1:0] dir_y;
	logic signed [W-1:0] dir_z;
	logic signed [W-1:0] near_limit;
	logic signed [W-1:0] far_limit;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		near_limit, far_limit, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		near_limit, far_limit, output ready);
endinterface

interface rbsi_hit_if #(parameter int W = 32);
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic signed [W-1:0]  hit_t;
	logic signed [W-1:0]  point_x;
	logic signed [W-1:0]  point_y;
	logic signed [W-1:0]  point_z;
	rbsi_pkg::axis_t      normal_axis;
	logic                 normal_negative;
	logic                 front_face;
	rbsi_pkg::mat_t       hit_material;

	modport source (output valid, hit, hit_t, point_x, point_y, point_z, normal_axis,
		normal_negative, front_face, hit_material, input ready);
	modport sink (input valid, hit, hit_t, point_x, point_y, point_z, normal_axis,
		normal_negative, front_face, hit_material, output ready);
endinterface

interface rbsi_cfg_if #(parameter int W = 32);
	logic               valid;
	logic               ready;
	rbsi_pkg::cfg_idx_t index;
	logic [W-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/rbsi_div_pipe.sv -----
module rbsi_div_pipe #(
	parameter int NW    = 49,
	parameter int DW    = 32,
	parameter int LANES = 6,
	parameter int SW    = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [LANES-1:0][NW-1:0]    in_num,
	input  logic [LANES-1:0][DW-1:0]    in_den,
	input  logic [SW-1:0]               in_side,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [LANES-1:0][NW-1:0]    out_quo,
	output logic [SW-1:0]               out_side
);
	// restoring division, one quotient bit per stage, all lanes in lockstep
	logic [NW-1:0]                  vld_s;
	logic [NW-1:0]                  en;
	logic [LANES-1:0][DW-1:0]       rem_s  [NW];
	logic [LANES-1:0][DW-1:0]       den_s  [NW];
	logic [LANES-1:0][NW-1:0]       quo_s  [NW];
	logic [SW-1:0]                  side_s [NW];

	for (genvar j = 0; j < NW; j++) begin : g_stage
		logic                     vin;
		logic [LANES-1:0][DW-1:0] rem_in;
		logic [LANES-1:0][DW-1:0] den_in;
		logic [LANES-1:0][NW-1:0] quo_in;
		logic [SW-1:0]            side_in;
		logic [LANES-1:0][DW-1:0] rem_nx;
		logic [LANES-1:0][NW-1:0] quo_nx;

		if (j == 0) begin : g_first
			assign vin     = in_valid;
			assign rem_in  = '0;
			assign den_in  = in_den;
			assign quo_in  = in_num;
			assign side_in = in_side;
		end else begin : g_next
			assign vin     = vld_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign den_in  = den_s[j-1];
			assign quo_in  = quo_s[j-1];
			assign side_in = side_s[j-1];
		end

		if (j == NW-1) begin : g_en_last
			assign en[j] = !vld_s[j] || out_ready;
		end else begin : g_en_mid
			assign en[j] = !vld_s[j] || en[j+1];
		end

		always_comb begin
			logic [DW:0] trial;
			logic [DW:0] diff;
			logic        ge;
			for (int l = 0; l < LANES; l++) begin
				trial     = {rem_in[l], quo_in[l][NW-1]};
				diff      = trial - {1'b0, den_in[l]};
				ge        = trial >= {1'b0, den_in[l]};
				rem_nx[l] = ge ? diff[DW-1:0] : trial[DW-1:0];
				quo_nx[l] = {quo_in[l][NW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en[j]) begin
				vld_s[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j]  <= rem_nx;
				den_s[j]  <= den_in;
				quo_s[j]  <= quo_nx;
				side_s[j] <= side_in;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[NW-1];
	assign out_quo   = quo_s[NW-1];
	assign out_side  = side_s[NW-1];

endmodule

// ----- src/ray_box_slab_intersection_core.sv -----
// Channel | Dir | Carries
// ray     | in  | origin_x/y/z, dir_x/y/z, near_limit, far_limit
// res     | out | hit, hit_t, point_x/y/z, normal_axis, normal_negative, front_face, hit_material
// cfg     | in  | index, data (box corners, material)
//
// One ray per cycle while the result channel is not stalled. Coordinates default to Q16.16;
// the slab divider resolves one quotient bit per stage.
// arst_n clears all valid bits and the box registers.
// A stage holds while the one after it is full and stalled; empty stages fill
// behind a stalled output, so nothing is dropped or repeated.
module ray_box_slab_intersection_core #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	rbsi_cfg_if.sink   cfg,
	rbsi_ray_if.sink   ray,
	rbsi_hit_if.source res
);
	import rbsi_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int NW = W + F + 1;
	localparam int QW = NW + 1;
	localparam int LW = QW / 2;
	localparam int HW = QW - LW;
	localparam int PW = W + QW;
	localparam int CW = W + 3;
	localparam int MW = 2 * W + 2;
	localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic [5:0]           qneg;
		logic [W-1:0]         nlim;
		logic [W-1:0]         flim;
		logic [2:0][W-1:0]    o;
		logic [2:0][W-1:0]    d;
	} side_t;
	localparam int SW = $bits(side_t);

	function automatic logic signed [W-1:0] sat_w(input logic signed [PW:0] v);
		logic signed [PW:0] hi_lim;
		logic signed [PW:0] lo_lim;
		hi_lim = (PW+1)'(MAXV);
		lo_lim = (PW+1)'(MINV);
		if (v > hi_lim) return MAXV;
		else if (v < lo_lim) return MINV;
		else return v[W-1:0];
	endfunction

	// configuration
	logic signed [W-1:0] bmin_q [3];
	logic signed [W-1:0] bmax_q [3];
	mat_t                mat_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				bmin_q[a] <= '0;
				bmax_q[a] <= '0;
			end
			mat_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_BOX_MIN_X: bmin_q[0] <= cfg.data;
				CFG_BOX_MIN_Y: bmin_q[1] <= cfg.data;
				CFG_BOX_MIN_Z: bmin_q[2] <= cfg.data;
				CFG_BOX_MAX_X: bmax_q[0] <= cfg.data;
				CFG_BOX_MAX_Y: bmax_q[1] <= cfg.data;
				CFG_BOX_MAX_Z: bmax_q[2] <= cfg.data;
				CFG_MATERIAL:  mat_q <= cfg.data[MAT_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake chain
	logic en_s1, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;
	logic vld_s1, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic div_in_ready, div_out_valid;

	assign en_s9     = !vld_s9 || res.ready;
	assign en_s8     = !vld_s8 || en_s9;
	assign en_s7     = !vld_s7 || en_s8;
	assign en_s6     = !vld_s6 || en_s7;
	assign en_s5     = !vld_s5 || en_s6;
	assign en_s4     = !vld_s4 || en_s5;
	assign en_s3     = !vld_s3 || en_s4;
	assign en_s1     = !vld_s1 || div_in_ready;
	assign ray.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= ray.valid;
			if (en_s3) vld_s3 <= div_out_valid;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
			if (en_s9) vld_s9 <= vld_s8;
		end
	end

	// s1: slab numerators and divisor magnitudes
	logic signed [W-1:0]    o_in [3];
	logic signed [W-1:0]    d_in [3];
	logic signed [W:0]      dif_c [6];
	logic [W:0]             dmag_c [6];
	logic [5:0][NW-1:0]     num_c;
	logic [5:0][W-1:0]      den_c;
	side_t                  side_c;
	logic [5:0][NW-1:0]     num_s1;
	logic [5:0][W-1:0]      den_s1;
	side_t                  side_s1;

	assign o_in[0] = ray.origin_x;
	assign o_in[1] = ray.origin_y;
	assign o_in[2] = ray.origin_z;
	assign d_in[0] = ray.dir_x;
	assign d_in[1] = ray.dir_y;
	assign d_in[2] = ray.dir_z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dif_c[a]   = {bmin_q[a][W-1], bmin_q[a]} - {o_in[a][W-1], o_in[a]};
			dif_c[a+3] = {bmax_q[a][W-1], bmax_q[a]} - {o_in[a][W-1], o_in[a]};
			den_c[a]   = d_in[a][W-1] ? -d_in[a] : d_in[a];
			den_c[a+3] = den_c[a];
			side_c.o[a] = o_in[a];
			side_c.d[a] = d_in[a];
		end
		for (int k = 0; k < 6; k++) begin
			dmag_c[k] = dif_c[k][W] ? -dif_c[k] : dif_c[k];
			num_c[k]  = {dmag_c[k], {F{1'b0}}};
		end
		for (int a = 0; a < 3; a++) begin
			side_c.qneg[a]   = dif_c[a][W] ^ d_in[a][W-1];
			side_c.qneg[a+3] = dif_c[a+3][W] ^ d_in[a][W-1];
		end
		side_c.nlim = ray.near_limit;
		side_c.flim = ray.far_limit;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			num_s1  <= num_c;
			den_s1  <= den_c;
			side_s1 <= side_c;
		end
	end

	logic [5:0][NW-1:0] quo_d;
	logic [SW-1:0]      side_dv;
	side_t              side_d;

	rbsi_div_pipe #(
		.NW    (NW),
		.DW    (W),
		.LANES (6),
		.SW    (SW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (div_in_ready),
		.in_num    (num_s1),
		.in_den    (den_s1),
		.in_side   (side_s1),
		.out_valid (div_out_valid),
		.out_ready (en_s3),
		.out_quo   (quo_d),
		.out_side  (side_dv)
	);

	assign side_d = side_t'(side_dv);

	// s3: signed slab distances, interval narrowing
	logic signed [QW-1:0] qs_c [6];
	logic signed [QW-1:0] t0_c [3];
	logic signed [QW-1:0] t1_c [3];
	logic signed [QW-1:0] tlo_c, thi_c;
	logic                 tlo_none_c, thi_none_c, emiss_c;

	logic signed [QW-1:0] tlo_s3, thi_s3;
	logic                 tlo_none_s3, thi_none_s3, emiss_s3;
	logic signed [W-1:0]  o_s3 [3];
	logic signed [W-1:0]  d_s3 [3];
	logic signed [W-1:0]  nlim_s3, flim_s3;

	always_comb begin
		logic signed [W-1:0] oa, da;
		for (int k = 0; k < 6; k++) begin
			qs_c[k] = side_d.qneg[k] ? -$signed({1'b0, quo_d[k]}) : $signed({1'b0, quo_d[k]});
		end
		tlo_c      = '0;
		thi_c      = '0;
		tlo_none_c = 1'b1;
		thi_none_c = 1'b1;
		emiss_c    = 1'b0;
		for (int a = 0; a < 3; a++) begin
			oa = side_d.o[a];
			da = side_d.d[a];
			t0_c[a] = da[W-1] ? qs_c[a+3] : qs_c[a];
			t1_c[a] = da[W-1] ? qs_c[a] : qs_c[a+3];
			if (bmax_q[a] <= bmin_q[a]) emiss_c = 1'b1;
			if (da == '0) begin
				// flat direction: passes only from inside the slab
				if (oa < bmin_q[a] || oa > bmax_q[a]) emiss_c = 1'b1;
			end else begin
				if (tlo_none_c || t0_c[a] > tlo_c) begin
					tlo_c      = t0_c[a];
					tlo_none_c = 1'b0;
				end
				if (thi_none_c || t1_c[a] < thi_c) begin
					thi_c      = t1_c[a];
					thi_none_c = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			tlo_s3      <= tlo_c;
			thi_s3      <= thi_c;
			tlo_none_s3 <= tlo_none_c;
			thi_none_s3 <= thi_none_c;
			emiss_s3    <= emiss_c;
			for (int a = 0; a < 3; a++) begin
				o_s3[a] <= side_d.o[a];
				d_s3[a] <= side_d.d[a];
			end
			nlim_s3 <= side_d.nlim;
			flim_s3 <= side_d.flim;
		end
	end

	// s4: limits, hit decision, partial products of dir * t
	logic                     miss_c;
	logic signed [W+LW:0]     plo_c [3];
	logic signed [W+HW-1:0]   phi_c [3];

	logic                     hit_s4;
	logic signed [W-1:0]      hit_t_s4;
	logic signed [W+LW:0]     plo_s4 [3];
	logic signed [W+HW-1:0]   phi_s4 [3];
	logic signed [W-1:0]      o_s4 [3];
	logic [2:0]               dneg_s4, dpos_s4;

	always_comb begin
		miss_c = emiss_s3 || tlo_none_s3
			|| (!thi_none_s3 && thi_s3 <= tlo_s3)
			|| (tlo_s3 < QW'(nlim_s3))
			|| (flim_s3 != MAXV && tlo_s3 > QW'(flim_s3));
		for (int a = 0; a < 3; a++) begin
			plo_c[a] = d_s3[a] * $signed({1'b0, tlo_s3[LW-1:0]});
			phi_c[a] = d_s3[a] * $signed(tlo_s3[QW-1:LW]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			hit_s4   <= !miss_c;
			hit_t_s4 <= sat_w((PW+1)'(tlo_s3));
			for (int a = 0; a < 3; a++) begin
				plo_s4[a]  <= plo_c[a];
				phi_s4[a]  <= phi_c[a];
				o_s4[a]    <= o_s3[a];
				dneg_s4[a] <= d_s3[a][W-1];
				dpos_s4[a] <= !d_s3[a][W-1] && (d_s3[a] != '0);
			end
		end
	end

	// s5: full product
	logic                 hit_s5;
	logic signed [W-1:0]  hit_t_s5;
	logic signed [PW-1:0] full_s5 [3];
	logic signed [W-1:0]  o_s5 [3];
	logic [2:0]           dneg_s5, dpos_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			hit_s5   <= hit_s4;
			hit_t_s5 <= hit_t_s4;
			dneg_s5  <= dneg_s4;
			dpos_s5  <= dpos_s4;
			for (int a = 0; a < 3; a++) begin
				full_s5[a] <= (PW'(phi_s4[a]) <<< LW) + PW'(plo_s4[a]);
				o_s5[a]    <= o_s4[a];
			end
		end
	end

	// s6: hit point, floor of the fixed-point product, saturated
	logic                 hit_s6;
	logic signed [W-1:0]  hit_t_s6;
	logic signed [W-1:0]  p_s6 [3];
	logic [2:0]           dneg_s6, dpos_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			hit_s6   <= hit_s5;
			hit_t_s6 <= hit_t_s5;
			dneg_s6  <= dneg_s5;
			dpos_s6  <= dpos_s5;
			for (int a = 0; a < 3; a++) begin
				p_s6[a] <= sat_w((PW+1)'(full_s5[a] >>> F) + (PW+1)'(o_s5[a]));
			end
		end
	end

	// s7: offset from the box centre, doubled
	logic signed [CW-1:0] c_c [3];
	logic [CW-1:0]        cabs_c [3];

	logic                 hit_s7;
	logic signed [W-1:0]  hit_t_s7;
	logic signed [W-1:0]  p_s7 [3];
	logic [W+1:0]         ac_s7 [3];
	logic [2:0]           pos_s7, dneg_s7, dpos_s7;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			c_c[a]    = (CW'(p_s6[a]) <<< 1) - CW'(bmin_q[a]) - CW'(bmax_q[a]);
			cabs_c[a] = c_c[a][CW-1] ? -c_c[a] : c_c[a];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			hit_s7   <= hit_s6;
			hit_t_s7 <= hit_t_s6;
			dneg_s7  <= dneg_s6;
			dpos_s7  <= dpos_s6;
			for (int a = 0; a < 3; a++) begin
				p_s7[a]   <= p_s6[a];
				ac_s7[a]  <= cabs_c[a][W+1:0];
				pos_s7[a] <= !c_c[a][CW-1] && (c_c[a] != '0);
			end
		end
	end

	// s8: cross products for the extent-normalized comparison
	logic [W-1:0]         ext_c [3];
	logic                 hit_s8;
	logic signed [W-1:0]  hit_t_s8;
	logic signed [W-1:0]  p_s8 [3];
	logic [2:0]           pos_s8, dneg_s8, dpos_s8;
	logic [MW-1:0]        m01_s8, m10_s8, m02_s8, m20_s8, m12_s8, m21_s8;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			ext_c[a] = bmax_q[a] - bmin_q[a];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			hit_s8   <= hit_s7;
			hit_t_s8 <= hit_t_s7;
			pos_s8   <= pos_s7;
			dneg_s8  <= dneg_s7;
			dpos_s8  <= dpos_s7;
			for (int a = 0; a < 3; a++) begin
				p_s8[a] <= p_s7[a];
			end
			m01_s8 <= ac_s7[0] * ext_c[1];
			m10_s8 <= ac_s7[1] * ext_c[0];
			m02_s8 <= ac_s7[0] * ext_c[2];
			m20_s8 <= ac_s7[2] * ext_c[0];
			m12_s8 <= ac_s7[1] * ext_c[2];
			m21_s8 <= ac_s7[2] * ext_c[1];
		end
	end

	// s9: normal selection and output register
	axis_t axis_c;
	logic  pos_out_c, front_c, neg_c;

	always_comb begin
		priority if (m01_s8 > m10_s8 && m02_s8 > m20_s8) axis_c = AXIS_X;
		else if (m12_s8 > m21_s8) axis_c = AXIS_Y;
		else axis_c = AXIS_Z;
		pos_out_c = pos_s8[axis_c];
		front_c   = pos_out_c ? dneg_s8[axis_c] : dpos_s8[axis_c];
		neg_c     = front_c ? !pos_out_c : pos_out_c;
	end

	assign res.valid = vld_s9;

	always_ff @(posedge clk) begin
		if (en_s9) begin
			res.hit             <= hit_s8;
			res.hit_t           <= hit_s8 ? hit_t_s8 : '0;
			res.point_x         <= hit_s8 ? p_s8[0] : '0;
			res.point_y         <= hit_s8 ? p_s8[1] : '0;
			res.point_z         <= hit_s8 ? p_s8[2] : '0;
			res.normal_axis     <= hit_s8 ? axis_c : AXIS_X;
			res.normal_negative <= hit_s8 && neg_c;
			res.front_face      <= hit_s8 && front_c;
			res.hit_material    <= hit_s8 ? mat_q : '0;
		end
	end

endmodule

// ----- src/rbsi_chk.sv -----
module rbsi_chk #(
	parameter int W = 32
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic              hit,
	input logic [W-1:0]      hit_t,
	input logic [W-1:0]      point_x,
	input logic [W-1:0]      point_y,
	input logic [W-1:0]      point_z,
	input rbsi_pkg::axis_t   normal_axis,
	input logic              normal_negative,
	input logic              front_face,
	input rbsi_pkg::mat_t    hit_material
);
	import rbsi_pkg::*;

	localparam int CNT_W = 10;

	// rays in flight, counted at the ports
	logic [CNT_W-1:0] pend_q;
	logic             acc_in, acc_out;

	assign acc_in  = in_valid && in_ready;
	assign acc_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + CNT_W'(acc_in) - CNT_W'(acc_out);
		end
	end

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_t == '0 && point_x == '0 && point_y == '0
			&& point_z == '0 && normal_axis == AXIS_X && !normal_negative
			&& !front_face && hit_material == '0)
		else $error("miss transaction with nonzero fields");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("result without an accepted ray");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(hit) && $stable(hit_t) && $stable(point_x)
			&& $stable(point_y) && $stable(point_z) && $stable(normal_axis))
		else $error("result changed while stalled");

endmodule

bind ray_box_slab_intersection_core rbsi_chk #(.W(COORD_WIDTH)) u_rbsi_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (ray.valid),
	.in_ready        (ray.ready),
	.out_valid       (res.valid),
	.out_ready       (res.ready),
	.hit             (res.hit),
	.hit_t           (res.hit_t),
	.point_x         (res.point_x),
	.point_y         (res.point_y),
	.point_z         (res.point_z),
	.normal_axis     (res.normal_axis),
	.normal_negative (res.normal_negative),
	.front_face      (res.front_face),
	.hit_material    (res.hit_material)
);
